// File: hdl/etc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etc_pkg
// shared types and constants for the elapsed time comparator
// ----------------------------------------------------------------------------
package etc_pkg;

  localparam int unsigned TickW   = 32;
  localparam int unsigned ClkW    = 8;
  localparam int unsigned PreW    = 16;
  localparam int unsigned ProdW   = TickW + PreW + 1;
  localparam int unsigned LimW    = TickW + ClkW;
  localparam int unsigned AddrW   = 4;
  localparam int unsigned DataW   = 32;

  localparam logic [ClkW-1:0]  ClockMhzRst  = 8'd16;
  localparam logic [PreW-1:0]  PrescalerRst = 16'd0;
  localparam logic [TickW-1:0] ReloadRst    = 32'd65535;

  // register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_CLOCK_MHZ = 2'd0,
    REG_PRESCALER = 2'd1,
    REG_RELOAD    = 2'd2,
    REG_NONE      = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIST,
    S_SUM,
    S_MUL,
    S_CMP
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic delta;
    logic sum;
    logic mul;
    logic finish;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

// File: hdl/etc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etc_ctrl
// sequencer stepping one request through distance, sum, multiply and compare
// ----------------------------------------------------------------------------
module etc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  etc_pkg::sts_t sts,
  output etc_pkg::cmd_t cmd
);
  import etc_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DIST;
      end
      S_DIST: state_nxt = S_SUM;
      S_SUM:  state_nxt = S_MUL;
      S_MUL:  state_nxt = S_CMP;
      S_CMP: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      S_DIST: cmd.delta = 1'b1;
      S_SUM:  cmd.sum  = 1'b1;
      S_MUL:  cmd.mul  = 1'b1;
      S_CMP:  cmd.finish = sts.out_free;
      default: cmd = '0;
    endcase
  end

  a_load_to_dist: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == S_DIST)
    else $error("load not followed by distance step");

  a_finish_in_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (state_r == S_CMP && sts.out_free))
    else $error("result written outside compare step");

  a_cmp_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP && !sts.out_free) |=> state_r == S_CMP)
    else $error("compare step left while output slot busy");

endmodule

// File: hdl/etc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etc_dp
// tick accumulation, scaling and threshold compare with output register
// ----------------------------------------------------------------------------
module etc_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  etc_pkg::cmd_t              cmd,
  output etc_pkg::sts_t              sts,
  input  logic [etc_pkg::ClkW-1:0]   clock_mhz,
  input  logic [etc_pkg::PreW-1:0]   prescaler,
  input  logic [etc_pkg::TickW-1:0]  reload_value,
  input  logic [etc_pkg::TickW-1:0]  in_counter_sample,
  input  logic                       in_restart,
  input  logic [etc_pkg::TickW-1:0]  in_target_us,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_reached
);
  import etc_pkg::*;

  logic [TickW-1:0] smp_r, tgt_r, dist_r, dist_nxt;
  logic             rst_flag_r;
  logic [TickW-1:0] acc_r, acc_nxt, ref_r, ref_nxt;
  logic [ProdW-1:0] prod_r;
  logic [LimW-1:0]  lim_r;
  logic             out_valid_r, out_valid_nxt, out_reached_r;
  logic [TickW:0]   wrap_up, wrap_diff, sum_c;
  logic [PreW:0]    pre_p1;
  logic [ClkW-1:0]  div_c;
  logic             reached_c;

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      smp_r      <= in_counter_sample;
      rst_flag_r <= in_restart;
      tgt_r      <= in_target_us;
    end
  end

  // wrap-aware distance, clamped at zero and at the tick limit
  always_comb begin
    wrap_up   = {1'b0, reload_value} + {{TickW{1'b0}}, 1'b1} + {1'b0, smp_r};
    wrap_diff = wrap_up - {1'b0, ref_r};
    if (smp_r >= ref_r) begin
      dist_nxt = smp_r - ref_r;
    end else if (wrap_up <= {1'b0, ref_r}) begin
      dist_nxt = '0;
    end else if (wrap_diff[TickW]) begin
      dist_nxt = '1;
    end else begin
      dist_nxt = wrap_diff[TickW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.delta) dist_r <= dist_nxt;
  end

  // saturating accumulate, restart and reached clear
  assign sum_c     = {1'b0, acc_r} + {1'b0, dist_r};
  assign reached_c = !rst_flag_r && (prod_r >= {{(ProdW-LimW){1'b0}}, lim_r});

  always_comb begin
    acc_nxt = acc_r;
    ref_nxt = ref_r;
    if (cmd.sum) begin
      ref_nxt = smp_r;
      if (rst_flag_r) begin
        acc_nxt = '0;
      end else if (sum_c[TickW]) begin
        acc_nxt = '1;
      end else begin
        acc_nxt = sum_c[TickW-1:0];
      end
    end else if (cmd.finish && reached_c) begin
      acc_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      ref_r <= '0;
    end else begin
      acc_r <= acc_nxt;
      ref_r <= ref_nxt;
    end
  end

  // ticks*(pre+1) against target*clock_mhz replaces the division
  assign pre_p1 = {1'b0, prescaler} + {{PreW{1'b0}}, 1'b1};
  assign div_c  = (clock_mhz == '0) ? {{(ClkW-1){1'b0}}, 1'b1} : clock_mhz;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= ProdW'(acc_r) * ProdW'(pre_p1);
      lim_r  <= LimW'(tgt_r) * LimW'(div_c);
    end
  end

  // output register
  assign sts.out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (cmd.finish) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) out_reached_r <= reached_c;
  end

  assign out_valid   = out_valid_r;
  assign out_reached = out_reached_r;

  a_restart_not_reached: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && rst_flag_r) |=> !out_reached_r)
    else $error("restart reported as reached");

  a_reached_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && reached_c) |=> acc_r == '0)
    else $error("total not cleared after reached");

  a_finish_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid_r || !out_stall))
    else $error("result overwrote a pending one");

endmodule

// File: hdl/elapsed_time_comparator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elapsed_time_comparator_core
// non-blocking delay check on sampled free-running timer counter values
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_stall): one request carries a counter sample,
//   a restart flag and a target delay in microseconds. a restart takes the
//   sample as reference and answers not reached; otherwise the wrap-aware
//   distance is added to a saturating tick total and compared against target.
//   result channel (out_valid / out_stall): one reached bit per request.
//   config port: apb-style, clock_mhz at 0x0, prescaler at 0x4, reload at 0x8,
//   write only while idle; pready is tied high, reads return the registers.
//   timing: a request is taken in idle, then the four-step sequencer runs
//   distance, sum, multiply and compare; the result is written in compare and
//   the next request can be taken in the cycle after that, so the block takes
//   no new request while one is in its steps. the output register lets a new
//   request start while a result still waits; a stalled receiver holds the
//   sequencer in compare only if the slot is still full at that point.
//   reset: tick total and reference clear, registers return to 16 / 0 / 65535.
// ----------------------------------------------------------------------------
module elapsed_time_comparator_core (
  input  logic                       clk,
  input  logic                       rst_n,
  // config port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [etc_pkg::AddrW-1:0]  paddr,
  input  logic [etc_pkg::DataW-1:0]  pwdata,
  output logic [etc_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  // request input
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [etc_pkg::TickW-1:0]  in_counter_sample,
  input  logic                       in_restart,
  input  logic [etc_pkg::TickW-1:0]  in_target_us,
  // result output
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_reached
);
  import etc_pkg::*;

  logic [ClkW-1:0]  clock_mhz_r;
  logic [PreW-1:0]  prescaler_r;
  logic [TickW-1:0] reload_r;
  reg_idx_t         reg_idx;
  logic             cfg_wr;
  cmd_t             cmd;
  sts_t             sts;

  // register decode, byte offset bits ignored
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_mhz_r <= ClockMhzRst;
      prescaler_r <= PrescalerRst;
      reload_r    <= ReloadRst;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_CLOCK_MHZ: clock_mhz_r <= pwdata[ClkW-1:0];
        REG_PRESCALER: prescaler_r <= pwdata[PreW-1:0];
        REG_RELOAD:    reload_r    <= pwdata[TickW-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (reg_idx)
      REG_CLOCK_MHZ: prdata = {{(DataW-ClkW){1'b0}}, clock_mhz_r};
      REG_PRESCALER: prdata = {{(DataW-PreW){1'b0}}, prescaler_r};
      REG_RELOAD:    prdata = reload_r;
      default:       prdata = '0;
    endcase
  end

  // sequencer
  etc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // arithmetic and result register
  etc_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .clock_mhz         (clock_mhz_r),
    .prescaler         (prescaler_r),
    .reload_value      (reload_r),
    .in_counter_sample (in_counter_sample),
    .in_restart        (in_restart),
    .in_target_us      (in_target_us),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_reached       (out_reached)
  );

endmodule

// File: tb/sv/tb_elapsed_time_comparator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_elapsed_time_comparator_core
// self-checking bench for the elapsed time comparator core
// ----------------------------------------------------------------------------
// a directed table walks the corners first: zero target, restart, counter
// wrap, samples above the reload value, zero clock, saturating tick total and
// a write to an unused register address. random phases follow, each with its
// own register setting, made mostly of restart-led runs of counter samples
// that climb and wrap like a real timer, mixed with noise requests. every
// reached bit is checked against a local model of the tick bookkeeping.
// ----------------------------------------------------------------------------
module tb_elapsed_time_comparator_core;
  import etc_pkg::*;

  localparam int DrainCycles = 12;
  localparam int StallLimit  = 2000;  // cycles with no handshake at all
  localparam int PhaseItems  = 235;
  localparam int NumPhases   = 8;
  localparam int DirRows     = 23;

  // directed table columns
  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;
  typedef enum logic [1:0] {EXP_MODEL, EXP_LOW, EXP_HIGH} row_exp_t;

  typedef struct packed {
    row_kind_t   kind;
    reg_idx_t    reg_sel;
    logic [31:0] wdata;
    logic [31:0] sample;
    logic        restart;
    logic [31:0] target;
    row_exp_t    exp_col;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [AddrW-1:0]  paddr = '0;
  logic [DataW-1:0]  pwdata = '0;
  logic [DataW-1:0]  prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [TickW-1:0]  in_counter_sample = '0;
  logic              in_restart = 1'b0;
  logic [TickW-1:0]  in_target_us = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_reached;

  elapsed_time_comparator_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_counter_sample (in_counter_sample),
    .in_restart        (in_restart),
    .in_target_us      (in_target_us),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_reached       (out_reached)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the registers and of the tick bookkeeping
  logic [ClkW-1:0]  mhz_shadow;
  logic [PreW-1:0]  presc_shadow;
  logic [TickW-1:0] reload_shadow;
  logic [TickW-1:0] tick_total;
  logic [TickW-1:0] last_count;

  // reached bits still owed by the block, oldest first
  logic reached_q[$];

  int fails = 0;
  int idle_cycles = 0;
  int gap_div = 0;      // sender pause odds, 0 = never
  int stall_div = 0;    // receiver stall odds, 0 = never
  int stall_left = 0;

  // directed corners, run with the reset register values at first
  stim_row_t dir_rows [DirRows] = '{
    // zero target answers reached straight after reset
    '{ROW_ITEM, REG_NONE, 32'd0, 32'd0, 1'b0, 32'd0, EXP_HIGH},
    // restart always answers not reached
    '{ROW_ITEM, REG_NONE, 32'd0, 32'd0, 1'b1, 32'd0, EXP_LOW},
    '{ROW_ITEM, REG_NONE, 32'd0, 32'd16, 1'b0, 32'd1, EXP_MODEL},
    '{ROW_ITEM, REG_NONE, 32'd0, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, EXP_LOW},
    // reference above reload, distance clamps to zero
    '{ROW_ITEM, REG_NONE, 32'd0, 32'd5, 1'b0, 32'd1, EXP_MODEL},
    '{ROW_ITEM, REG_NONE, 32'd0, 32'd65535, 1'b0, 32'hFFFF_FFFF, EXP_MODEL},
    // counter wrap at the reload value
    '{ROW_ITEM, REG_NONE, 32'd0, 32'd10, 1'b0, 32'hFFFF_FFFF, EXP_MODEL},
    '{ROW_ITEM, REG_NONE, 32'd0, 32'd0, 1'b0, 32'd0, EXP_HIGH},
    // zero clock divides by one
    '{ROW_CFG, REG_CLOCK_MHZ, 32'd0, 32'd0, 1'b0, 32'd0, EXP_MODEL},
    '{ROW_ITEM, REG_NONE, 32'd0, 32'd0, 1'b1, 32'd0, EXP_LOW},
    '{ROW_ITEM, REG_NONE, 32'd0, 32'd1000, 1'b0, 32'd1000, EXP_MODEL},
    // widest product
    '{ROW_CFG, REG_PRESCALER, 32'h0000_FFFF, 32'd0, 1'b0, 32'd0, EXP_MODEL},
    '{ROW_CFG, REG_RELOAD, 32'hFFFF_FFFF, 32'd0, 1'b0, 32'd0, EXP_MODEL},
    '{ROW_CFG, REG_CLOCK_MHZ, 32'd255, 32'd0, 1'b0, 32'd0, EXP_MODEL},
    '{ROW_ITEM, REG_NONE, 32'd0, 32'd0, 1'b1, 32'hFFFF_FFFF, EXP_LOW},
    '{ROW_ITEM, REG_NONE, 32'd0, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, EXP_MODEL},
    // saturating tick total
    '{ROW_CFG, REG_PRESCALER, 32'd0, 32'd0, 1'b0, 32'd0, EXP_MODEL},
    '{ROW_ITEM, REG_NONE, 32'd0, 32'd0, 1'b1, 32'hFFFF_FFFF, EXP_LOW},
    '{ROW_ITEM, REG_NONE, 32'd0, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, EXP_MODEL},
    '{ROW_ITEM, REG_NONE, 32'd0, 32'hFFFF_FFFE, 1'b0, 32'hFFFF_FFFF, EXP_MODEL},
    // unused address, must leave the registers alone
    '{ROW_CFG, REG_NONE, 32'h1234_5678, 32'd0, 1'b0, 32'd0, EXP_MODEL},
    '{ROW_ITEM, REG_NONE, 32'd0, 32'hFFFF_FFFF, 1'b0, 32'h0101_0101, EXP_MODEL},
    '{ROW_ITEM, REG_NONE, 32'd0, 32'd0, 1'b0, 32'd0, EXP_HIGH}
  };

  // wrap-aware tick distance from the reference to a new sample
  function automatic logic [TickW-1:0] wrap_distance(input logic [TickW-1:0] base_cnt,
                                                     input logic [TickW-1:0] now_cnt);
    logic [TickW:0] up;
    if (now_cnt >= base_cnt) return now_cnt - base_cnt;
    up = 33'(reload_shadow) + 33'd1 + 33'(now_cnt);
    // reference beyond reload: no negative distance
    if (up <= 33'(base_cnt)) return '0;
    up = up - 33'(base_cnt);
    if (up[TickW]) return '1;
    return up[TickW-1:0];
  endfunction

  // updates the tick bookkeeping for one request and returns its reached bit
  function automatic logic advance_timer(input logic [TickW-1:0] sample,
                                         input logic restart,
                                         input logic [TickW-1:0] target);
    logic [TickW:0]   total;
    logic [ProdW-1:0] scaled;
    logic [ProdW-1:0] usec;
    logic [ClkW-1:0]  divisor;
    if (restart) begin
      last_count = sample;
      tick_total = '0;
      return 1'b0;
    end
    total = 33'(tick_total) + 33'(wrap_distance(last_count, sample));
    if (total[TickW]) total = 33'(32'hFFFF_FFFF);  // saturate, never wrap
    tick_total = total[TickW-1:0];
    last_count = sample;
    divisor = (mhz_shadow == '0) ? 8'd1 : mhz_shadow;
    scaled = ProdW'(tick_total) * ProdW'(17'(presc_shadow) + 17'd1);
    usec = scaled / ProdW'(divisor);
    if (usec >= ProdW'(target)) begin
      tick_total = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // one request; the owed reached bit is logged when the handshake is seen
  task automatic send_req(input logic [TickW-1:0] sample, input logic restart,
                          input logic [TickW-1:0] target, input row_exp_t exp_col);
    bit   taken;
    logic modeled;
    if (gap_div != 0 && $urandom_range(0, gap_div) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_counter_sample <= sample;
    in_restart        <= restart;
    in_target_us      <= target;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      if (taken) begin
        modeled = advance_timer(sample, restart, target);
        if (exp_col == EXP_MODEL) reached_q.push_back(modeled);
        else reached_q.push_back(exp_col == EXP_HIGH);
      end
      @(posedge clk);
    end
  endtask

  // stop sending and let the block run dry
  task automatic drain_block();
    in_valid <= 1'b0;
    while (reached_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // apb write, setup then access; the shadow follows at the access edge
  task automatic write_reg(input reg_idx_t idx, input logic [DataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_CLOCK_MHZ: mhz_shadow = value[ClkW-1:0];
      REG_PRESCALER: presc_shadow = value[PreW-1:0];
      REG_RELOAD:    reload_shadow = value[TickW-1:0];
      default: ;     // unused address, ignored
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [TickW-1:0] pick_reload();
    case ($urandom_range(0, 2))
      0:       return $urandom_range(0, 1000);
      1:       return $urandom_range(0, 65535);
      default: return $urandom();
    endcase
  endfunction

  // one random phase: new register setting, then timer-like request runs
  task automatic run_phase(input logic [ClkW-1:0] mhz, input logic [PreW-1:0] pre,
                           input logic [TickW-1:0] rld, input bit calm);
    longint unsigned cnt;
    longint unsigned step;
    longint unsigned cap;
    longint unsigned scale;
    longint unsigned top;
    logic [TickW-1:0] tgt;
    int run_left;
    int pause_at;
    drain_block();
    // upper pwdata bits are junk now and then, the block must drop them
    write_reg(REG_CLOCK_MHZ, {($urandom_range(0, 1) != 0) ? 24'($urandom()) : 24'd0, mhz});
    write_reg(REG_PRESCALER, {($urandom_range(0, 1) != 0) ? 16'($urandom()) : 16'd0, pre});
    write_reg(REG_RELOAD, rld);
    if ($urandom_range(0, 1) != 0) write_reg(REG_NONE, $urandom());
    gap_div   = calm ? 0 : $urandom_range(0, 4);
    stall_div = calm ? 0 : $urandom_range(0, 4);
    cap       = (rld < 4096) ? longint'(rld) : longint'($urandom_range(16, 4096));
    scale     = cap * (longint'(pre) + 1) / ((mhz == 0) ? 1 : longint'(mhz));
    pause_at  = $urandom_range(1, PhaseItems - 1);
    run_left  = 0;
    cnt       = 0;
    for (int i = 0; i < PhaseItems; i++) begin
      // sender waits out every owed result once per phase
      if (i == pause_at) drain_block();
      if ($urandom_range(0, 99) < 15) begin
        send_req($urandom(), 1'($urandom_range(0, 1)), $urandom(), EXP_MODEL);
      end else if (run_left == 0) begin
        cnt = $urandom_range(0, rld);
        run_left = $urandom_range(1, 24);
        send_req(32'(cnt), 1'b1, $urandom(), EXP_MODEL);
      end else begin
        step = ($urandom_range(0, 7) == 0) ? longint'($urandom_range(0, rld))
                                           : longint'($urandom_range(0, 32'(cap)));
        cnt = cnt + step;
        if (cnt > longint'(rld)) cnt = cnt - (longint'(rld) + 1);
        case ($urandom_range(0, 9))
          0:       top = 0;
          1, 2:    top = 64'hFFFF_FFFF;
          3, 4, 5: top = scale;
          default: top = scale * 6;
        endcase
        if (top > 64'hFFFF_FFFF) top = 64'hFFFF_FFFF;
        tgt = (top == 64'hFFFF_FFFF) ? $urandom() : $urandom_range(0, 32'(top));
        run_left--;
        send_req(32'(cnt), 1'b0, tgt, EXP_MODEL);
      end
    end
  endtask

  // receiver stalls in short bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (rst_n && stall_div != 0 && $urandom_range(0, stall_div) == 0) begin
      stall_left <= $urandom_range(0, 2);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result checker and watchdog, sampled mid-cycle
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (reached_q.size() == 0) begin
        $display("%0t: result with nothing owed, actual reached %0b", $time, out_reached);
        fails++;
      end else if (out_reached !== reached_q[0]) begin
        $display("%0t: reached mismatch, expected %0b actual %0b",
                 $time, reached_q[0], out_reached);
        fails++;
        void'(reached_q.pop_front());
      end else begin
        void'(reached_q.pop_front());
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("%0t: no handshake for %0d cycles", $time, StallLimit);
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    mhz_shadow    = ClockMhzRst;
    presc_shadow  = PrescalerRst;
    reload_shadow = ReloadRst;
    tick_total    = '0;
    last_count    = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners with some light idling
    gap_div   = 3;
    stall_div = 3;
    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        drain_block();
        write_reg(dir_rows[r].reg_sel, dir_rows[r].wdata);
      end else begin
        send_req(dir_rows[r].sample, dir_rows[r].restart, dir_rows[r].target,
                 dir_rows[r].exp_col);
      end
    end

    // reset values, the extremes, then random settings; last phase runs flat out
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: run_phase(ClockMhzRst, PrescalerRst, ReloadRst, 1'b0);
        1: run_phase(8'd1, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
        2: run_phase(8'd255, 16'd0, 32'd0, 1'b0);
        3: run_phase(8'd0, 16'($urandom()), 32'd1000, 1'b0);
        default: run_phase(8'($urandom()), 16'($urandom()), pick_reload(), p == NumPhases - 1);
      endcase
    end

    in_valid <= 1'b0;
    while (reached_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (fails == 0 && reached_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
